FILE: sv/art_pkg.sv
package art_pkg;

    localparam int TIME_W = 32;
    localparam int OBJ_W = 32;
    localparam int INST_W = 16;
    localparam int SLOT_W = 4;
    localparam int KIND_W = 3;
    localparam int REQ_W = 2;
    localparam int CNT_W = 32;
    localparam int RETRY_W = 4;
    localparam int TIMEOUT_W = 16;
    localparam int LIMIT_W = 3;
    localparam int NEXP_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACK = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;
    localparam logic [REQ_W-1:0] REQ_STATS = 2'd3;

    localparam logic [KIND_W-1:0] RES_ACCEPTED = 3'd0;
    localparam logic [KIND_W-1:0] RES_FULL = 3'd1;
    localparam logic [KIND_W-1:0] RES_RESEND = 3'd2;
    localparam logic [KIND_W-1:0] RES_ABANDONED = 3'd3;
    localparam logic [KIND_W-1:0] RES_ACK_OK = 3'd4;
    localparam logic [KIND_W-1:0] RES_ACK_UNEXP = 3'd5;
    localparam logic [KIND_W-1:0] RES_STATS = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'b1;

    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 16'd250;
    localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST = 3'd2;

    // At most this many expired slots are handled by one event.
    localparam logic [NEXP_W-1:0] MAX_EXPIRED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OBJ_W-1:0] obj;
        logic [INST_W-1:0] inst;
        logic [SLOT_W-1:0] slot;
        logic last;
    } res_t;

    // The request token that walks down the row of slot cells.
    typedef struct packed {
        logic vld;
        logic [REQ_W-1:0] req;
        logic [TIME_W-1:0] now_ms;
        logic [OBJ_W-1:0] obj;
        logic [INST_W-1:0] inst;
        logic found;
        logic [SLOT_W-1:0] idx;
        logic [NEXP_W-1:0] n_exp;
        logic hold_vld;
        res_t hold;
    } tok_t;

    typedef struct packed {
        logic push;
        res_t res;
        logic inc_abandon;
        logic inc_resend;
    } cell_evt_t;

endpackage

FILE: sv/art_req_if.sv
interface art_req_if
    import art_pkg::*;
;
    logic valid;
    logic ready;
    logic [REQ_W-1:0] req_type;
    logic [TIME_W-1:0] now_ms;
    logic [OBJ_W-1:0] object_id;
    logic [INST_W-1:0] instance_id;

    modport source (output valid, req_type, now_ms, object_id, instance_id, input ready);
    modport sink (input valid, req_type, now_ms, object_id, instance_id, output ready);
endinterface

FILE: sv/art_res_if.sv
interface art_res_if
    import art_pkg::*;
;
    logic valid;
    logic ready;
    logic [KIND_W-1:0] result_kind;
    logic [OBJ_W-1:0] result_object;
    logic [INST_W-1:0] result_instance;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0] error_total;
    logic [CNT_W-1:0] retry_total;
    logic last;

    modport source (
        output valid, result_kind, result_object, result_instance, slot_index,
               error_total, retry_total, last,
        input ready
    );
    modport sink (
        input valid, result_kind, result_object, result_instance, slot_index,
              error_total, retry_total, last,
        output ready
    );
endinterface

FILE: sv/art_cell.sv
module art_cell
    import art_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic [TIMEOUT_W-1:0] ack_timeout,
    input  logic [LIMIT_W-1:0]   retry_limit,
    input  tok_t                 tok_in,
    output tok_t                 tok_out,
    output cell_evt_t            evt
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

    logic                 valid_reg;
    logic                 valid_next;
    logic [OBJ_W-1:0]     obj_reg;
    logic [OBJ_W-1:0]     obj_next;
    logic [INST_W-1:0]    inst_reg;
    logic [INST_W-1:0]    inst_next;
    logic [TIME_W-1:0]    deadline_reg;
    logic [TIME_W-1:0]    deadline_next;
    logic [RETRY_W-1:0]   retries_reg;
    logic [RETRY_W-1:0]   retries_next;
    tok_t                 tok_reg;
    tok_t                 tok_next;

    logic                 act;
    logic                 is_hk;
    logic                 expired;
    logic                 abandon;
    logic                 resend;
    logic                 take;
    logic                 ack_hit;
    logic [TIME_W-1:0]    new_deadline;
    res_t                 exp_res;

    assign act = tok_in.vld && go;
    assign is_hk = (tok_in.req == REQ_ADD) || (tok_in.req == REQ_TICK);
    assign new_deadline = tok_in.now_ms + {{(TIME_W-TIMEOUT_W){1'b0}}, ack_timeout};

    always_comb
    begin
        expired = act && is_hk && valid_reg && (tok_in.now_ms > deadline_reg)
                  && (tok_in.n_exp < MAX_EXPIRED);
        abandon = expired && (retries_reg > {1'b0, retry_limit});
        resend = expired && !abandon;
        // A slot freed by housekeeping in this same pass is free for the add.
        take = act && (tok_in.req == REQ_ADD) && !tok_in.found
               && (!valid_reg || abandon);
        ack_hit = act && (tok_in.req == REQ_ACK) && !tok_in.found && valid_reg
                  && (obj_reg == tok_in.obj) && (inst_reg == tok_in.inst);

        exp_res.kind = abandon ? RES_ABANDONED : RES_RESEND;
        exp_res.obj = obj_reg;
        exp_res.inst = inst_reg;
        exp_res.slot = MY_SLOT;
        exp_res.last = 1'b0;

        valid_next = valid_reg;
        obj_next = obj_reg;
        inst_next = inst_reg;
        deadline_next = deadline_reg;
        retries_next = retries_reg;
        if (take)
        begin
            valid_next = 1'b1;
            obj_next = tok_in.obj;
            inst_next = tok_in.inst;
            deadline_next = new_deadline;
            retries_next = '0;
        end
        else if (abandon || ack_hit)
        begin
            valid_next = 1'b0;
        end
        else if (resend)
        begin
            retries_next = retries_reg + 1'b1;
            deadline_next = new_deadline;
        end

        tok_next = tok_in;
        evt = '0;
        evt.inc_abandon = abandon;
        evt.inc_resend = resend;
        if (expired)
        begin
            tok_next.n_exp = tok_in.n_exp + 1'b1;
            if (tok_in.req == REQ_TICK)
            begin
                // The newest tick result is held back until it is known
                // whether another one follows it.
                evt.push = tok_in.hold_vld;
                evt.res = tok_in.hold;
                tok_next.hold_vld = 1'b1;
                tok_next.hold = exp_res;
            end
            else
            begin
                evt.push = 1'b1;
                evt.res = exp_res;
            end
        end
        if (take || ack_hit)
        begin
            tok_next.found = 1'b1;
            tok_next.idx = MY_SLOT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg <= '0;
        end
        else if (go)
        begin
            valid_reg <= valid_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obj_reg <= obj_next;
        inst_reg <= inst_next;
        deadline_reg <= deadline_next;
        retries_reg <= retries_next;
    end

    assign tok_out = tok_reg;

endmodule

FILE: sv/ack_retransmit_tracker.sv
// Channel  Dir  Interface    Payload
// req      in   art_req_if   req_type, now_ms, object_id, instance_id
// res      out  art_res_if   result_kind, result_object, result_instance, slot_index,
//                            error_total, retry_total, last
//
// One transaction at a time walks the row of SLOTS slot cells, one cell per cycle.
// Ready stays low from an acceptance until the token leaves the last cell, so the next item
// is accepted only after the previous one has walked the whole row.
// Results leave through one output register; a stalled output freezes the whole row.
// rst_n clears the slot valid bits, counters and handshake state and reloads the reset configuration.
// Configuration writes take effect at once and are meant for idle periods.
module ack_retransmit_tracker
    import art_pkg::*;
#(
    parameter int SLOTS = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    art_req_if.sink               req,
    art_res_if.source             res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [TIMEOUT_W-1:0] ack_timeout_reg;
    logic [LIMIT_W-1:0]   retry_limit_reg;
    logic                 busy_reg;
    logic                 busy_next;
    tok_t                 entry_reg;
    tok_t                 entry_next;
    logic [CNT_W-1:0]     abandon_reg;
    logic [CNT_W-1:0]     abandon_next;
    logic [CNT_W-1:0]     resend_reg;
    logic [CNT_W-1:0]     resend_next;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    res_t                 out_res_reg;
    res_t                 out_res_next;
    logic [CNT_W-1:0]     out_err_reg;
    logic [CNT_W-1:0]     out_err_next;
    logic [CNT_W-1:0]     out_rty_reg;
    logic [CNT_W-1:0]     out_rty_next;

    tok_t                 tok_link [SLOTS+1];
    cell_evt_t            cell_evt [SLOTS];
    tok_t                 fin;
    logic                 go;
    logic                 accept;
    logic                 push;
    res_t                 push_res;
    logic                 inc_abandon;
    logic                 inc_resend;
    logic                 stats_out;

    assign go = !out_vld_reg || res.ready;
    assign accept = req.valid && !busy_reg;
    assign req.ready = !busy_reg;

    assign tok_link[0] = entry_reg;
    assign fin = tok_link[SLOTS];

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            art_cell #(
                .INDEX (g)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .go          (go),
                .ack_timeout (ack_timeout_reg),
                .retry_limit (retry_limit_reg),
                .tok_in      (tok_link[g]),
                .tok_out     (tok_link[g+1]),
                .evt         (cell_evt[g])
            );
        end
    endgenerate

    always_comb
    begin
        entry_next = entry_reg;
        if (accept)
        begin
            entry_next = '0;
            entry_next.vld = 1'b1;
            entry_next.req = req.req_type;
            entry_next.now_ms = req.now_ms;
            entry_next.obj = req.object_id;
            entry_next.inst = req.instance_id;
        end
        else if (go)
        begin
            entry_next.vld = 1'b0;
        end
    end

    always_comb
    begin
        push = 1'b0;
        push_res = '0;
        inc_abandon = 1'b0;
        inc_resend = 1'b0;
        stats_out = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            inc_abandon = inc_abandon | cell_evt[i].inc_abandon;
            inc_resend = inc_resend | cell_evt[i].inc_resend;
            if (cell_evt[i].push)
            begin
                push = 1'b1;
                push_res = cell_evt[i].res;
            end
        end

        // The token leaving the last cell produces the closing result; a tick with no expired slot produces none.
        if (fin.vld && go)
        begin
            push_res.last = 1'b1;
            push_res.obj = fin.obj;
            push_res.inst = fin.inst;
            push_res.slot = fin.found ? fin.idx : '0;
            case (fin.req)
                REQ_ADD:
                begin
                    push = 1'b1;
                    push_res.kind = fin.found ? RES_ACCEPTED : RES_FULL;
                end
                REQ_ACK:
                begin
                    push = 1'b1;
                    push_res.kind = fin.found ? RES_ACK_OK : RES_ACK_UNEXP;
                end
                REQ_TICK:
                begin
                    push = fin.hold_vld;
                    push_res = fin.hold;
                    push_res.last = 1'b1;
                end
                REQ_STATS:
                begin
                    push = 1'b1;
                    stats_out = 1'b1;
                    push_res.kind = RES_STATS;
                    push_res.obj = '0;
                    push_res.inst = '0;
                    push_res.slot = '0;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        abandon_next = abandon_reg;
        resend_next = resend_reg;
        if (stats_out)
        begin
            abandon_next = '0;
            resend_next = '0;
        end
        else
        begin
            if (inc_abandon)
            begin
                abandon_next = abandon_reg + 1'b1;
            end
            if (inc_resend)
            begin
                resend_next = resend_reg + 1'b1;
            end
        end

        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (fin.vld && go)
        begin
            busy_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        out_res_next = out_res_reg;
        out_err_next = out_err_reg;
        out_rty_next = out_rty_reg;
        if (go)
        begin
            out_vld_next = push;
            out_res_next = push_res;
            out_err_next = stats_out ? abandon_reg : '0;
            out_rty_next = stats_out ? resend_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg <= ACK_TIMEOUT_RST;
            retry_limit_reg <= RETRY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data;
                CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:         ack_timeout_reg <= ack_timeout_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            entry_reg <= '0;
            abandon_reg <= '0;
            resend_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            entry_reg <= entry_next;
            abandon_reg <= abandon_next;
            resend_reg <= resend_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
        out_err_reg <= out_err_next;
        out_rty_reg <= out_rty_next;
    end

    assign res.valid = out_vld_reg;
    assign res.result_kind = out_res_reg.kind;
    assign res.result_object = out_res_reg.obj;
    assign res.result_instance = out_res_reg.inst;
    assign res.slot_index = out_res_reg.slot;
    assign res.error_total = out_err_reg;
    assign res.retry_total = out_rty_reg;
    assign res.last = out_res_reg.last;

endmodule

FILE: verif/ack_retransmit_tracker_test.sv
module ack_retransmit_tracker_test;
    import art_pkg::*;

    localparam int SLOTS = 3;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = SLOTS + 10;
    localparam int POOL = 8;
    localparam int PHASE_ITEMS = 89;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [TIME_W-1:0] now_ms;
        logic [OBJ_W-1:0]  obj;
        logic [INST_W-1:0] inst;
        bit                typed;
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
    } req_item_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [OBJ_W-1:0]  obj;
        logic [INST_W-1:0] inst;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  errs;
        logic [CNT_W-1:0]  rtys;
        logic              last;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    art_req_if req_ch ();
    art_res_if res_ch ();

    ack_retransmit_tracker #(.SLOTS(SLOTS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the pending-message table and its counters.
    bit                 mirror_valid [SLOTS];
    logic [OBJ_W-1:0]   mirror_obj [SLOTS];
    logic [INST_W-1:0]  mirror_inst [SLOTS];
    logic [TIME_W-1:0]  mirror_deadline [SLOTS];
    logic [RETRY_W-1:0] mirror_retries [SLOTS];
    logic [CNT_W-1:0]   abandon_tally;
    logic [CNT_W-1:0]   resend_tally;
    logic [TIMEOUT_W-1:0] timeout_cfg;
    logic [LIMIT_W-1:0]   limit_cfg;

    outcome_t  awaited_results [$];
    req_item_t current_item;
    req_item_t directed_rows [$];

    int failures;
    int items_accepted;
    int results_checked;
    int settings_used;
    int kind_seen [7];
    int idle_cycles;
    int burst_left;
    int ready_cycle;
    int stall_mode;
    logic [15:0] ready_pattern;

    logic [TIME_W-1:0] clock_ms;
    logic [OBJ_W-1:0]  pool_obj [POOL];
    logic [INST_W-1:0] pool_inst [POOL];

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void queue_outcome(logic [KIND_W-1:0] kind, logic [OBJ_W-1:0] obj,
                                          logic [INST_W-1:0] inst, logic [SLOT_W-1:0] slot,
                                          logic [CNT_W-1:0] errs, logic [CNT_W-1:0] rtys);
        outcome_t o;
        o.kind = kind;
        o.obj = obj;
        o.inst = inst;
        o.slot = slot;
        o.errs = errs;
        o.rtys = rtys;
        o.last = 1'b0;
        awaited_results.push_back(o);
    endfunction

    // Walks the valid slots in index order and handles up to MAX_EXPIRED of those past their deadline.
    function automatic void expire_slots(logic [TIME_W-1:0] now_ms);
        int handled;
        handled = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (handled >= int'(MAX_EXPIRED))
                break;
            if (mirror_valid[i] && now_ms > mirror_deadline[i])
            begin
                if (mirror_retries[i] > {1'b0, limit_cfg})
                begin
                    mirror_valid[i] = 1'b0;
                    abandon_tally = abandon_tally + 1;
                    queue_outcome(RES_ABANDONED, mirror_obj[i], mirror_inst[i], SLOT_W'(i), 0, 0);
                end
                else
                begin
                    mirror_retries[i] = mirror_retries[i] + 1'b1;
                    mirror_deadline[i] = now_ms + TIME_W'(timeout_cfg);
                    resend_tally = resend_tally + 1;
                    queue_outcome(RES_RESEND, mirror_obj[i], mirror_inst[i], SLOT_W'(i), 0, 0);
                end
                handled++;
            end
        end
    endfunction

    function automatic void predict_outcomes(req_item_t it);
        int queued_prior;
        int hit;
        queued_prior = awaited_results.size();
        hit = -1;
        case (it.req)
            REQ_ADD:
            begin
                expire_slots(it.now_ms);
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!mirror_valid[i])
                        hit = i;
                if (hit >= 0)
                begin
                    mirror_valid[hit] = 1'b1;
                    mirror_obj[hit] = it.obj;
                    mirror_inst[hit] = it.inst;
                    mirror_deadline[hit] = it.now_ms + TIME_W'(timeout_cfg);
                    mirror_retries[hit] = '0;
                    queue_outcome(RES_ACCEPTED, it.obj, it.inst, SLOT_W'(hit), 0, 0);
                end
                else
                    queue_outcome(RES_FULL, it.obj, it.inst, '0, 0, 0);
            end
            REQ_ACK:
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (mirror_valid[i] && mirror_obj[i] == it.obj && mirror_inst[i] == it.inst)
                        hit = i;
                if (hit >= 0)
                begin
                    mirror_valid[hit] = 1'b0;
                    queue_outcome(RES_ACK_OK, it.obj, it.inst, SLOT_W'(hit), 0, 0);
                end
                else
                    queue_outcome(RES_ACK_UNEXP, it.obj, it.inst, '0, 0, 0);
            end
            REQ_TICK:
                expire_slots(it.now_ms);
            default:
            begin
                queue_outcome(RES_STATS, '0, '0, '0, abandon_tally, resend_tally);
                abandon_tally = '0;
                resend_tally = '0;
            end
        endcase
        if (awaited_results.size() > queued_prior)
        begin
            awaited_results[awaited_results.size() - 1].last = 1'b1;
            // Rows with a hand-written answer are checked against that answer.
            if (it.typed)
            begin
                awaited_results[awaited_results.size() - 1].kind = it.kind;
                awaited_results[awaited_results.size() - 1].slot = it.slot;
            end
        end
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        outcome_t o;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_checked++;
                if (res_ch.result_kind < 7)
                    kind_seen[res_ch.result_kind]++;
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result of kind %0d arrived with nothing expected",
                             $time, res_ch.result_kind);
                    failures++;
                end
                else
                begin
                    o = awaited_results.pop_front();
                    compare_field("result_kind", 32'(o.kind), 32'(res_ch.result_kind));
                    compare_field("result_object", o.obj, res_ch.result_object);
                    compare_field("result_instance", 32'(o.inst), 32'(res_ch.result_instance));
                    compare_field("slot_index", 32'(o.slot), 32'(res_ch.slot_index));
                    compare_field("error_total", o.errs, res_ch.error_total);
                    compare_field("retry_total", o.rtys, res_ch.retry_total);
                    compare_field("last", 32'(o.last), 32'(res_ch.last));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                items_accepted++;
                predict_outcomes(current_item);
            end
        end
    end

    // Any cycle without a transaction on either channel counts toward the hang limit.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, awaited_results.size());
                $display("ack_retransmit_tracker_test failed");
                $finish;
            end
        end
    end

    // The receiver switches between always-ready, a random pattern and a sparse pattern.
    always @(negedge clk)
    begin
        if (ready_cycle % 64 == 0)
            stall_mode = $urandom_range(0, 2);
        if (ready_cycle % 16 == 0)
        begin
            ready_pattern = 16'($urandom);
            if (stall_mode == 2)
                ready_pattern = ready_pattern & 16'($urandom) & 16'($urandom);
            ready_pattern[$urandom_range(0, 15)] = 1'b1;
        end
        res_ch.ready = (stall_mode == 0) ? 1'b1 : ready_pattern[ready_cycle % 16];
        ready_cycle++;
    end

    function automatic req_item_t make_row(logic [REQ_W-1:0] req, logic [TIME_W-1:0] now_ms,
                                           logic [OBJ_W-1:0] obj, logic [INST_W-1:0] inst,
                                           bit typed, logic [KIND_W-1:0] kind,
                                           logic [SLOT_W-1:0] slot);
        req_item_t r;
        r.req = req;
        r.now_ms = now_ms;
        r.obj = obj;
        r.inst = inst;
        r.typed = typed;
        r.kind = kind;
        r.slot = slot;
        return r;
    endfunction

    function automatic req_item_t random_item();
        req_item_t r;
        int roll;
        int k;
        r = make_row(REQ_TICK, '0, '0, '0, 1'b0, RES_ACCEPTED, '0);
        roll = $urandom_range(0, 99);
        if (roll < 12)
        begin
            r.req = REQ_W'($urandom_range(0, 3));
            r.now_ms = $urandom;
            r.obj = $urandom;
            r.inst = INST_W'($urandom);
            return r;
        end
        roll = $urandom_range(0, 9);
        if (roll < 6)
            clock_ms = clock_ms + $urandom_range(0, timeout_cfg / 2);
        else if (roll < 9)
            clock_ms = clock_ms + $urandom_range(timeout_cfg, 2 * timeout_cfg + 1);
        r.now_ms = clock_ms;
        k = $urandom_range(0, POOL - 1);
        r.obj = pool_obj[k];
        r.inst = pool_inst[k];
        roll = $urandom_range(0, 99);
        if (roll < 38)
            r.req = REQ_ADD;
        else if (roll < 70)
        begin
            r.req = REQ_ACK;
            // Near misses: same object, instance off by one bit.
            if ($urandom_range(0, 6) == 0)
                r.inst[$urandom_range(0, INST_W - 1)] ^= 1'b1;
        end
        else if (roll < 94)
            r.req = REQ_TICK;
        else
            r.req = REQ_STATS;
        return r;
    endfunction

    // Entered and left at a falling edge; valid stays high when the next item follows at once.
    task automatic send_item(req_item_t it);
        if (burst_left == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        current_item = it;
        req_ch.req_type = it.req;
        req_ch.now_ms = it.now_ms;
        req_ch.object_id = it.obj;
        req_ch.instance_id = it.inst;
        req_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic settle();
        req_ch.valid = 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        if (idx == CFG_ACK_TIMEOUT)
            timeout_cfg = data;
        else
            limit_cfg = LIMIT_W'(data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic run_phase(logic [TIMEOUT_W-1:0] timeout, logic [LIMIT_W-1:0] limit,
                             logic [TIME_W-1:0] start_ms, bit pause_midway);
        settle();
        write_reg(CFG_ACK_TIMEOUT, timeout);
        write_reg(CFG_RETRY_LIMIT, CFG_DATA_W'(limit));
        settings_used++;
        clock_ms = start_ms;
        for (int i = 0; i < POOL; i++)
        begin
            pool_obj[i] = $urandom;
            pool_inst[i] = INST_W'($urandom);
        end
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (pause_midway && n == PHASE_ITEMS / 2)
                settle();
            send_item(random_item());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.now_ms = '0;
        req_ch.object_id = '0;
        req_ch.instance_id = '0;
        res_ch.ready = 1'b0;
        failures = 0;
        items_accepted = 0;
        results_checked = 0;
        settings_used = 1;
        idle_cycles = 0;
        burst_left = 0;
        ready_cycle = 0;
        stall_mode = 0;
        ready_pattern = '1;
        clock_ms = '0;
        foreach (kind_seen[i])
            kind_seen[i] = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            mirror_valid[i] = 1'b0;
            mirror_obj[i] = '0;
            mirror_inst[i] = '0;
            mirror_deadline[i] = '0;
            mirror_retries[i] = '0;
        end
        abandon_tally = '0;
        resend_tally = '0;
        timeout_cfg = ACK_TIMEOUT_RST;
        limit_cfg = RETRY_LIMIT_RST;
        current_item = make_row(REQ_TICK, '0, '0, '0, 1'b0, RES_ACCEPTED, '0);

        // Hand-written sequence under the reset settings: fill the table, duplicates,
        // partial ack matches, resend until abandoned, deadline wrap and a full sweep.
        directed_rows.push_back(make_row(REQ_STATS, 32'd0, 32'h0, 16'h0, 1'b1, RES_STATS, 4'd0));
        directed_rows.push_back(make_row(REQ_ACK, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                                         RES_ACK_UNEXP, 4'd0));
        directed_rows.push_back(make_row(REQ_ADD, 32'd0, 32'h0, 16'h0, 1'b1, RES_ACCEPTED, 4'd0));
        directed_rows.push_back(make_row(REQ_ADD, 32'd10, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                                         RES_ACCEPTED, 4'd1));
        directed_rows.push_back(make_row(REQ_ADD, 32'd20, 32'h0, 16'h0, 1'b1, RES_ACCEPTED, 4'd2));
        directed_rows.push_back(make_row(REQ_ADD, 32'd30, 32'h1234_5678, 16'h9ABC, 1'b1,
                                         RES_FULL, 4'd0));
        directed_rows.push_back(make_row(REQ_ACK, 32'd40, 32'h0, 16'h0, 1'b1, RES_ACK_OK, 4'd0));
        directed_rows.push_back(make_row(REQ_ACK, 32'd41, 32'h0, 16'h1, 1'b1,
                                         RES_ACK_UNEXP, 4'd0));
        directed_rows.push_back(make_row(REQ_ACK, 32'd42, 32'h1, 16'h0, 1'b1,
                                         RES_ACK_UNEXP, 4'd0));
        directed_rows.push_back(make_row(REQ_TICK, 32'd250, '0, '0, 1'b0, RES_ACCEPTED, '0));
        directed_rows.push_back(make_row(REQ_TICK, 32'd270, '0, '0, 1'b0, RES_ACCEPTED, '0));
        directed_rows.push_back(make_row(REQ_TICK, 32'd1000, '0, '0, 1'b0, RES_ACCEPTED, '0));
        directed_rows.push_back(make_row(REQ_TICK, 32'd2000, '0, '0, 1'b0, RES_ACCEPTED, '0));
        directed_rows.push_back(make_row(REQ_TICK, 32'd3000, '0, '0, 1'b0, RES_ACCEPTED, '0));
        directed_rows.push_back(make_row(REQ_ADD, 32'd4000, 32'hFFFF_0000, 16'h00FF, 1'b0,
                                         RES_ACCEPTED, '0));
        directed_rows.push_back(make_row(REQ_STATS, 32'd4000, '0, '0, 1'b0, RES_STATS, '0));
        directed_rows.push_back(make_row(REQ_ADD, 32'hFFFF_FFA0, 32'h0000_FFFF, 16'hFF00, 1'b0,
                                         RES_ACCEPTED, '0));
        directed_rows.push_back(make_row(REQ_TICK, 32'hFFFF_FFFF, '0, '0, 1'b0,
                                         RES_ACCEPTED, '0));
        directed_rows.push_back(make_row(REQ_TICK, 32'd0, '0, '0, 1'b0, RES_ACCEPTED, '0));
        directed_rows.push_back(make_row(REQ_ADD, 32'd0, 32'hA5A5_A5A5, 16'h5A5A, 1'b0,
                                         RES_ACCEPTED, '0));
        directed_rows.push_back(make_row(REQ_ADD, 32'h8000_0000, 32'h5A5A_5A5A, 16'hA5A5, 1'b0,
                                         RES_ACCEPTED, '0));
        directed_rows.push_back(make_row(REQ_TICK, 32'h8000_0000, '0, '0, 1'b0,
                                         RES_ACCEPTED, '0));
        directed_rows.push_back(make_row(REQ_STATS, 32'h8000_0001, '0, '0, 1'b0, RES_STATS, '0));
        directed_rows.push_back(make_row(REQ_ACK, 32'h8000_0002, 32'hA5A5_A5A5, 16'h5A5A, 1'b0,
                                         RES_ACCEPTED, '0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        run_phase(16'd1, 3'd0, $urandom, 1'b0);
        run_phase(16'hFFFF, 3'd7, 32'hFFFF_FFFF - $urandom_range(0, 400000), 1'b0);
        run_phase(TIMEOUT_W'($urandom_range(1, 65535)), LIMIT_W'($urandom_range(0, 7)),
                  $urandom, 1'b1);
        run_phase(TIMEOUT_W'($urandom_range(10, 500)), LIMIT_W'($urandom_range(0, 7)),
                  $urandom, 1'b0);
        run_phase(ACK_TIMEOUT_RST, LIMIT_W'($urandom_range(0, 7)),
                  32'hFFFF_FFFF - $urandom_range(0, 2000), 1'b0);

        settle();

        $display("Checked %0d results from %0d requests across %0d register settings.",
                 results_checked, items_accepted, settings_used);
        $display("Kinds: %0d acc %0d full %0d resend %0d aband %0d ack %0d unexp %0d stats.",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
                 kind_seen[5], kind_seen[6]);
        if (failures == 0)
            $display("ack_retransmit_tracker_test passed");
        else
            $display("ack_retransmit_tracker_test failed");
        $finish;
    end

endmodule
